### rtl/mfcc_pkg.sv
// shared types, constants and the crc byte update for the modbus frame crc checker
package mfcc_pkg;

   // frame limits and crc constants
   localparam int          MAX_FRAME_LENGTH = 255;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [15:0] CRC_PRESET       = 16'hFFFF;
   localparam logic [7:0]  MIN_LEN_RESET    = 8'd4;

   // register map
   localparam int          CSR_ADDR_W       = 3;
   localparam logic [0:0]  REG_MIN_LEN      = 1'b0;

   // input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   // result beat
   typedef struct packed {
      logic        frame_ok;
      logic        too_short;
      logic [7:0]  byte_count;
      logic [15:0] computed_crc;
   } rsp_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/mfcc_csr.sv
// apb-style register block holding the minimum frame length
module mfcc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mfcc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output logic [7:0]                         min_len
);

   logic [7:0] min_len_ff;
   logic [7:0] min_len_in;
   logic       wr_en;
   logic       sel_min;

   // address decode
   assign sel_min = (paddr[mfcc_pkg::CSR_ADDR_W-1] == mfcc_pkg::REG_MIN_LEN);
   assign wr_en   = psel && penable && pwrite && sel_min;

   // register update
   always_comb begin
      min_len_in = min_len_ff;
      if (wr_en) begin
         min_len_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= mfcc_pkg::MIN_LEN_RESET;
      end else begin
         min_len_ff <= min_len_in;
      end
   end

   // read back
   assign prdata  = sel_min ? {24'h000000, min_len_ff} : 32'h00000000;
   assign pready  = 1'b1;
   assign min_len = min_len_ff;

endmodule

### rtl/mfcc_frame_track.sv
// running crc, two-byte delay line, byte count and the end-of-frame verdict
module mfcc_frame_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  mfcc_pkg::req_type   item,
   input  logic [7:0]          min_len,
   output mfcc_pkg::rsp_type   verdict
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  old_ff, old_in;
   logic [7:0]  new_ff, new_in;
   logic [7:0]  seen_ff, seen_in;
   logic [15:0] crc_next;
   logic [8:0]  sum;
   logic [7:0]  count;
   logic [15:0] trailing;
   logic        too_short;

   // byte leaving the delay line is not part of the trailer
   assign crc_next = (seen_ff >= 8'd2) ? mfcc_pkg::crc_byte(crc_ff, old_ff) : crc_ff;

   // saturating count including this byte
   assign sum   = {1'b0, seen_ff} + 9'd1;
   assign count = (sum > 9'(mfcc_pkg::MAX_FRAME_LENGTH)) ?
                  8'(mfcc_pkg::MAX_FRAME_LENGTH) : sum[7:0];

   // verdict on the last byte
   assign trailing  = {item.data_byte, new_ff};
   assign too_short = count < min_len;

   always_comb begin
      verdict.frame_ok     = !too_short && (count >= 8'd2) && (crc_next == trailing);
      verdict.too_short    = too_short;
      verdict.byte_count   = count;
      verdict.computed_crc = crc_next;
   end

   // state advance, cleared after each frame
   always_comb begin
      crc_in  = crc_ff;
      old_in  = old_ff;
      new_in  = new_ff;
      seen_in = seen_ff;
      if (step) begin
         if (item.last) begin
            crc_in  = mfcc_pkg::CRC_PRESET;
            old_in  = 8'h00;
            new_in  = 8'h00;
            seen_in = 8'h00;
         end else begin
            crc_in  = crc_next;
            old_in  = new_ff;
            new_in  = item.data_byte;
            seen_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= mfcc_pkg::CRC_PRESET;
         old_ff  <= 8'h00;
         new_ff  <= 8'h00;
         seen_ff <= 8'h00;
      end else begin
         crc_ff  <= crc_in;
         old_ff  <= old_in;
         new_ff  <= new_in;
         seen_ff <= seen_in;
      end
   end

endmodule

### rtl/modbus_frame_crc_checker_core.sv
// top level of the modbus rtu frame crc checker
// Frame bytes enter one beat at a time on req, the final byte flagged by last; one result
// beat per frame leaves on rsp when the final byte has been processed. A byte is held
// in the input register; for the final byte, the verdict is then registered in the
// result register. The block takes one byte every cycle; only a final byte waits when
// an earlier result is still untaken. The limit is the eight-bit unrolled crc update.
// min_frame_length sits at byte address 0 and resets to 4; write it while idle.
module modbus_frame_crc_checker_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mfcc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mfcc_pkg::rsp_type                  rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mfcc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic              in_valid_ff, in_valid_in;
   mfcc_pkg::req_type in_ff, in_in;
   logic              out_valid_ff, out_valid_in;
   mfcc_pkg::rsp_type out_ff, out_in;
   mfcc_pkg::rsp_type verdict;
   logic [7:0]        min_len;
   logic              fire;

   // configuration registers
   mfcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .min_len (min_len)
   );

   // frame state and verdict
   mfcc_frame_track u_track (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .item    (in_ff),
      .min_len (min_len),
      .verdict (verdict)
   );

   // a held byte moves on unless it is final and the result slot stays full
   assign fire      = in_valid_ff && (!in_ff.last || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (fire && in_ff.last) begin
         out_valid_in = 1'b1;
         out_in       = verdict;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // a held byte only stalls when it is final and the result beat is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |-> in_ff.last && out_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   // a processed final byte always shows up as a result beat
   a_final_result: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.last |=> rsp_valid)
      else $error("final byte gave no result");

   // a good frame is never short and holds at least the two crc bytes
   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_ok |-> !rsp_data.too_short && (rsp_data.byte_count >= 8'd2))
      else $error("frame_ok with inconsistent length");
`endif

endmodule
